// ===== design/rto_pkg.sv =====
package rto_pkg;

    localparam int SIZE_BITS = 15;
    localparam int NUM_TRI   = 3;
    localparam int NUM_COR   = 4;
    localparam int NUM_SIDE  = NUM_COR * NUM_TRI;
    localparam int NUM_LANES = 2 * NUM_SIDE;

    typedef struct packed {
        logic neg;
        logic pos;
    } orient_sign_t;

endpackage

// ===== design/rto_orient_lane.sv =====
module rto_orient_lane #(
    parameter int PW = 17
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [PW-1:0]   o_x,
    input  logic signed [PW-1:0]   o_y,
    input  logic signed [PW-1:0]   a_x,
    input  logic signed [PW-1:0]   a_y,
    input  logic signed [PW-1:0]   b_x,
    input  logic signed [PW-1:0]   b_y,
    output rto_pkg::orient_sign_t  sign
);
    import rto_pkg::*;

    localparam int DW = PW + 1;
    localparam int MW = 2 * DW;

    logic signed [DW-1:0] dax_reg, dby_reg, day_reg, dbx_reg;
    logic signed [DW-1:0] dax_next, dby_next, day_next, dbx_next;
    logic signed [MW-1:0] p_reg, q_reg, p_next, q_next;
    orient_sign_t         sign_reg, sign_next;

    always_comb
    begin
        dax_next = DW'(a_x) - DW'(o_x);
        dby_next = DW'(b_y) - DW'(o_y);
        day_next = DW'(a_y) - DW'(o_y);
        dbx_next = DW'(b_x) - DW'(o_x);
        p_next   = MW'(dax_reg) * MW'(dby_reg);
        q_next   = MW'(day_reg) * MW'(dbx_reg);
        sign_next.pos = p_reg > q_reg;
        sign_next.neg = p_reg < q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg  <= dax_next;
            dby_reg  <= dby_next;
            day_reg  <= day_next;
            dbx_reg  <= dbx_next;
            p_reg    <= p_next;
            q_reg    <= q_next;
            sign_reg <= sign_next;
        end
    end

    assign sign = sign_reg;

endmodule

// ===== design/rto_decide.sv =====
module rto_decide (
    input  rto_pkg::orient_sign_t sign [rto_pkg::NUM_LANES],
    input  logic                  rect_hit,
    output logic                  overlaps
);
    import rto_pkg::*;

    logic [NUM_COR-1:0]  corner_in;
    logic [NUM_SIDE-1:0] crossing;

    always_comb
    begin
        for (int c = 0; c < NUM_COR; c++)
        begin
            logic neg;
            logic pos;
            neg = 1'b0;
            pos = 1'b0;
            for (int e = 0; e < NUM_TRI; e++)
            begin
                neg = neg | sign[c*NUM_TRI+e].neg;
                pos = pos | sign[c*NUM_TRI+e].pos;
            end
            corner_in[c] = !(neg && pos);
        end
        for (int j = 0; j < NUM_COR; j++)
        begin
            for (int i = 0; i < NUM_TRI; i++)
            begin
                orient_sign_t s1, s2, s3, s4;
                s1 = sign[j*NUM_TRI+i];
                s2 = sign[((j+1)%NUM_COR)*NUM_TRI+i];
                s3 = sign[NUM_SIDE+j*NUM_TRI+i];
                s4 = sign[NUM_SIDE+j*NUM_TRI+((i+1)%NUM_TRI)];
                crossing[j*NUM_TRI+i] = ((s1.neg && s2.pos) || (s1.pos && s2.neg))
                                     && ((s3.neg && s4.pos) || (s3.pos && s4.neg));
            end
        end
        overlaps = rect_hit || (|corner_in) || (|crossing);
    end

endmodule

// ===== design/rect_triangle_overlap_test_core.sv =====
// Rectangle/triangle overlap test. Each word carries an axis-aligned
// rectangle (left, top, width, height) and three triangle vertices; the
// answer says whether the shapes intersect or touch. The block takes one
// word per clock while the output word does not wait. The pipeline is an
// input register that forms the corners, then 24 orientation lanes of
// three stages each (coordinate differences, two signed multiplies of
// max(COORD_BITS,16)+2 bits, compare), then the output register that
// combines the signs. The whole pipeline holds while the output word
// waits, and bubbles pass through.
module rect_triangle_overlap_test_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_BITS-1:0]     rect_left,
    input  logic signed [COORD_BITS-1:0]     rect_top,
    input  logic [rto_pkg::SIZE_BITS-1:0]    rect_width,
    input  logic [rto_pkg::SIZE_BITS-1:0]    rect_height,
    input  logic signed [COORD_BITS-1:0]     tri_a_x,
    input  logic signed [COORD_BITS-1:0]     tri_a_y,
    input  logic signed [COORD_BITS-1:0]     tri_b_x,
    input  logic signed [COORD_BITS-1:0]     tri_b_y,
    input  logic signed [COORD_BITS-1:0]     tri_c_x,
    input  logic signed [COORD_BITS-1:0]     tri_c_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             overlaps
);
    import rto_pkg::*;

    localparam int CW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS + 1) + 1;
    localparam int XW = CW - COORD_BITS;
    localparam int ZW = CW - SIZE_BITS;

    logic adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic hit2_reg, hit3_reg, hit4_reg, overlaps_reg;
    logic hit2_next, overlaps_next;
    logic nz_reg, nz_next;

    logic signed [CW-1:0] tri_x_reg [NUM_TRI];
    logic signed [CW-1:0] tri_y_reg [NUM_TRI];
    logic signed [CW-1:0] cor_x_reg [NUM_COR];
    logic signed [CW-1:0] cor_y_reg [NUM_COR];
    logic signed [CW-1:0] tri_x_next [NUM_TRI];
    logic signed [CW-1:0] tri_y_next [NUM_TRI];
    logic signed [CW-1:0] cor_x_next [NUM_COR];
    logic signed [CW-1:0] cor_y_next [NUM_COR];

    orient_sign_t sign [NUM_LANES];

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign overlaps  = overlaps_reg;

    always_comb
    begin
        logic signed [CW-1:0] l, t, w, h;
        l = {{XW{rect_left[COORD_BITS-1]}}, rect_left};
        t = {{XW{rect_top[COORD_BITS-1]}}, rect_top};
        w = {{ZW{1'b0}}, rect_width};
        h = {{ZW{1'b0}}, rect_height};
        tri_x_next[0] = {{XW{tri_a_x[COORD_BITS-1]}}, tri_a_x};
        tri_y_next[0] = {{XW{tri_a_y[COORD_BITS-1]}}, tri_a_y};
        tri_x_next[1] = {{XW{tri_b_x[COORD_BITS-1]}}, tri_b_x};
        tri_y_next[1] = {{XW{tri_b_y[COORD_BITS-1]}}, tri_b_y};
        tri_x_next[2] = {{XW{tri_c_x[COORD_BITS-1]}}, tri_c_x};
        tri_y_next[2] = {{XW{tri_c_y[COORD_BITS-1]}}, tri_c_y};
        cor_x_next[0] = l;
        cor_y_next[0] = t;
        cor_x_next[1] = l + w;
        cor_y_next[1] = t;
        cor_x_next[2] = l;
        cor_y_next[2] = t + h;
        cor_x_next[3] = l + w;
        cor_y_next[3] = t + h;
        nz_next = (rect_width != '0) && (rect_height != '0);
    end

    always_comb
    begin
        hit2_next = 1'b0;
        for (int i = 0; i < NUM_TRI; i++)
        begin
            hit2_next = hit2_next
                || (tri_x_reg[i] >= cor_x_reg[0] && tri_x_reg[i] <= cor_x_reg[3]
                 && tri_y_reg[i] >= cor_y_reg[0] && tri_y_reg[i] <= cor_y_reg[3]);
        end
        hit2_next = hit2_next && nz_reg;
    end

    // corner against each triangle edge
    for (genvar c = 0; c < NUM_COR; c++)
    begin : g_corner
        for (genvar e = 0; e < NUM_TRI; e++)
        begin : g_edge
            rto_orient_lane #(.PW(CW)) u_lane (
                .clk  (clk),
                .en   (adv),
                .o_x  (cor_x_reg[c]),
                .o_y  (cor_y_reg[c]),
                .a_x  (tri_x_reg[e]),
                .a_y  (tri_y_reg[e]),
                .b_x  (tri_x_reg[(e+1)%NUM_TRI]),
                .b_y  (tri_y_reg[(e+1)%NUM_TRI]),
                .sign (sign[c*NUM_TRI+e])
            );
        end
    end

    // triangle vertex against each rectangle segment
    for (genvar j = 0; j < NUM_COR; j++)
    begin : g_seg
        for (genvar v = 0; v < NUM_TRI; v++)
        begin : g_vert
            rto_orient_lane #(.PW(CW)) u_lane (
                .clk  (clk),
                .en   (adv),
                .o_x  (cor_x_reg[j]),
                .o_y  (cor_y_reg[j]),
                .a_x  (cor_x_reg[(j+1)%NUM_COR]),
                .a_y  (cor_y_reg[(j+1)%NUM_COR]),
                .b_x  (tri_x_reg[v]),
                .b_y  (tri_y_reg[v]),
                .sign (sign[NUM_SIDE+j*NUM_TRI+v])
            );
        end
    end

    rto_decide u_decide (
        .sign     (sign),
        .rect_hit (hit4_reg),
        .overlaps (overlaps_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tri_x_reg    <= tri_x_next;
            tri_y_reg    <= tri_y_next;
            cor_x_reg    <= cor_x_next;
            cor_y_reg    <= cor_y_next;
            nz_reg       <= nz_next;
            hit2_reg     <= hit2_next;
            hit3_reg     <= hit2_reg;
            hit4_reg     <= hit3_reg;
            overlaps_reg <= overlaps_next;
        end
    end

    a_rect_hit_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && hit4_reg && adv) |=> (out_valid && overlaps))
        else $error("vertex inside rectangle did not give an overlap");

    a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("output word without a word in the last stage");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg}))
        else $error("pipeline moved while the output was stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted word did not enter the first stage");

endmodule
